[rtl/rgb_trapezoid_fade_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the fade sequencer blocks.
// ----------------------------------------------------------------------------
`ifndef RGB_TRAPEZOID_FADE_SEQUENCER_MACROS_SVH
`define RGB_TRAPEZOID_FADE_SEQUENCER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RTF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtf assertion failed");

// next-cycle implication, checked out of reset
`define RTF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtf assertion failed");

`endif

[rtl/rtf_pkg.sv]
// ----------------------------------------------------------------------------
// rtf_pkg
// Types, constants and register codes of the RGB trapezoid fade sequencer.
// ----------------------------------------------------------------------------
package rtf_pkg;

    localparam int RAMP_TICKS    = 1000;
    localparam int HOLD_TICKS    = 1000;

    localparam int FULL_LEVEL    = 255;
    localparam int TRAPEZOID_LEN = 3000;
    localparam int PERIOD_RESET  = 6000;

    localparam int COLOR_W    = 8;
    localparam int LEVEL_W    = 8;
    localparam int PERIOD_W   = 16;
    localparam int TICKS_W    = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int REM_W      = (RAMP_TICKS > 1) ? $clog2(RAMP_TICKS) : 1;
    localparam int LEVEL_STEP = FULL_LEVEL / RAMP_TICKS;
    localparam int LEVEL_FRAC = FULL_LEVEL % RAMP_TICKS;

    localparam logic [CFG_IDX_W-1:0] CFG_RED    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        PH_RISE = 2'd0,
        PH_HOLD = 2'd1,
        PH_FALL = 2'd2,
        PH_OFF  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        t_phase             phase;
    } t_seq_state;

    typedef struct packed {
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
        logic [PERIOD_W-1:0] period;
    } t_cfg;

endpackage

[rtl/rtf_if.sv]
// ----------------------------------------------------------------------------
// rtf interfaces
// Valid/ready channels for tick words, duty words and register writes.
// ----------------------------------------------------------------------------
interface rtf_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface rtf_duty_if;
    import rtf_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red_duty;
    logic [COLOR_W-1:0] green_duty;
    logic [COLOR_W-1:0] blue_duty;
    logic [LEVEL_W-1:0] brightness;
    logic [1:0]         fade_phase;

    modport source (output valid, output red_duty, output green_duty, output blue_duty,
                    output brightness, output fade_phase, input ready);
    modport sink   (input valid, input red_duty, input green_duty, input blue_duty,
                    input brightness, input fade_phase, output ready);
endinterface

interface rtf_cfg_if;
    import rtf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/rgb_trapezoid_fade_sequencer.sv]
// ----------------------------------------------------------------------------
// rgb_trapezoid_fade_sequencer
// Trapezoidal RGB breathing fade: one duty word per millisecond tick word.
// ----------------------------------------------------------------------------
// One tick word is taken every clock cycle unless the output stalls, and yields
// exactly one duty word: the sequencer stage updates the phase sequencer
// registers (phase, tick count, running ramp quotient and level), then the
// scaler stage scales the three colors by level/255 into the output register.
// A tick of 0 reports the current state without advancing. The pace is one
// word per cycle while the output is not stalled; a stalled output holds one
// word in the output register and one in the sequencer stage before the tick
// side is held off. Register writes (red, green, blue, cycle period) are meant
// for idle times; a period below 3000 is stored as 3000.
`include "rgb_trapezoid_fade_sequencer_macros.svh"

module rgb_trapezoid_fade_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtf_tick_if.sink    i_tick,
    rtf_cfg_if.sink     i_cfg,
    rtf_duty_if.source  o_duty
);
    import rtf_pkg::*;

    t_cfg       cfg;
    t_seq_state seq_state;

    logic r_s1_valid;
    logic n_s1_valid;
    logic r_out_valid;
    logic n_out_valid;
    logic s1_adv;
    logic in_acc;

    assign s1_adv       = !r_out_valid || o_duty.ready;
    assign i_tick.ready = !r_s1_valid || s1_adv;
    assign in_acc       = i_tick.valid && i_tick.ready;
    assign o_duty.valid = r_out_valid;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = r_s1_valid;
            n_s1_valid  = 1'b0;
        end
        if (in_acc) begin
            n_s1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    rtf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    rtf_sequencer u_sequencer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (in_acc && i_tick.tick),
        .i_period (cfg.period),
        .o_state  (seq_state)
    );

    rtf_scaler u_scaler (
        .i_clk        (i_clk),
        .i_load       (r_s1_valid && s1_adv),
        .i_state      (seq_state),
        .i_cfg        (cfg),
        .o_red_duty   (o_duty.red_duty),
        .o_green_duty (o_duty.green_duty),
        .o_blue_duty  (o_duty.blue_duty),
        .o_brightness (o_duty.brightness),
        .o_fade_phase (o_duty.fade_phase)
    );

    `RTF_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, r_s1_valid && r_out_valid && !o_duty.ready, !i_tick.ready)
    `RTF_ASSERT_NXT(a_s1_moves, i_clk, i_rst_n, r_s1_valid && s1_adv, r_out_valid)

endmodule

[rtl/rtf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rtf_cfg_regs
// Color and period registers; period writes are clamped to the trapezoid length.
// ----------------------------------------------------------------------------
module rtf_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rtf_cfg_if.sink        i_cfg,
    output rtf_pkg::t_cfg  o_cfg
);
    import rtf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_RED:    n_cfg.red   = i_cfg.data[COLOR_W-1:0];
                CFG_GREEN:  n_cfg.green = i_cfg.data[COLOR_W-1:0];
                CFG_BLUE:   n_cfg.blue  = i_cfg.data[COLOR_W-1:0];
                CFG_PERIOD: begin
                    if (i_cfg.data[PERIOD_W-1:0] < PERIOD_W'(TRAPEZOID_LEN)) begin
                        n_cfg.period = PERIOD_W'(TRAPEZOID_LEN);
                    end else begin
                        n_cfg.period = i_cfg.data[PERIOD_W-1:0];
                    end
                end
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red    <= '0;
            r_cfg.green  <= '0;
            r_cfg.blue   <= '0;
            r_cfg.period <= PERIOD_W'(PERIOD_RESET);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/rtf_sequencer.sv]
// ----------------------------------------------------------------------------
// rtf_sequencer
// Rise, hold, fall and off phase machine with a running ramp quotient.
// ----------------------------------------------------------------------------
`include "rgb_trapezoid_fade_sequencer_macros.svh"

module rtf_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic [rtf_pkg::PERIOD_W-1:0]   i_period,
    output rtf_pkg::t_seq_state            o_state
);
    import rtf_pkg::*;

    t_phase               r_phase;
    t_phase               n_phase;
    logic [TICKS_W-1:0]   r_ticks;
    logic [TICKS_W-1:0]   n_ticks;
    logic [LEVEL_W-1:0]   r_quo;
    logic [LEVEL_W-1:0]   n_quo;
    logic [REM_W-1:0]     r_rem;
    logic [REM_W-1:0]     n_rem;
    logic [LEVEL_W-1:0]   r_level;
    logic [LEVEL_W-1:0]   n_level;

    logic [TICKS_W-1:0]   ticks_inc;
    logic [REM_W:0]       rem_sum;
    logic                 rem_carry;
    logic [REM_W:0]       rem_next;
    logic [LEVEL_W:0]     quo_sum;
    logic [PERIOD_W-1:0]  off_len;

    assign o_state.level = r_level;
    assign o_state.phase = r_phase;

    always_comb begin
        ticks_inc = r_ticks + TICKS_W'(1);
        rem_sum   = {1'b0, r_rem} + (REM_W+1)'(LEVEL_FRAC);
        rem_carry = rem_sum >= (REM_W+1)'(RAMP_TICKS);
        rem_next  = rem_carry ? rem_sum - (REM_W+1)'(RAMP_TICKS) : rem_sum;
        quo_sum   = {1'b0, r_quo} + (LEVEL_W+1)'(LEVEL_STEP) + (LEVEL_W+1)'(rem_carry);
        off_len   = i_period - PERIOD_W'(TRAPEZOID_LEN);

        n_phase = r_phase;
        n_ticks = r_ticks;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_level = r_level;

        if (i_adv) begin
            n_ticks = ticks_inc;
            unique case (r_phase)
                PH_RISE: begin
                    n_quo   = quo_sum[LEVEL_W-1:0];
                    n_rem   = rem_next[REM_W-1:0];
                    n_level = quo_sum[LEVEL_W-1:0];
                    if (ticks_inc >= TICKS_W'(RAMP_TICKS)) begin
                        n_level = LEVEL_W'(FULL_LEVEL);
                        n_phase = PH_HOLD;
                        n_ticks = '0;
                        n_quo   = '0;
                        n_rem   = '0;
                    end
                end
                PH_HOLD: begin
                    n_level = LEVEL_W'(FULL_LEVEL);
                    if (ticks_inc >= TICKS_W'(HOLD_TICKS)) begin
                        n_phase = PH_FALL;
                        n_ticks = '0;
                    end
                end
                PH_FALL: begin
                    n_quo   = quo_sum[LEVEL_W-1:0];
                    n_rem   = rem_next[REM_W-1:0];
                    n_level = LEVEL_W'(FULL_LEVEL) - quo_sum[LEVEL_W-1:0];
                    if (ticks_inc >= TICKS_W'(RAMP_TICKS)) begin
                        n_level = '0;
                        n_phase = PH_OFF;
                        n_ticks = '0;
                        n_quo   = '0;
                        n_rem   = '0;
                    end
                end
                PH_OFF: begin
                    n_level = '0;
                    if (ticks_inc >= off_len) begin
                        n_phase = PH_RISE;
                        n_ticks = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RISE;
            r_ticks <= '0;
            r_quo   <= '0;
            r_rem   <= '0;
            r_level <= '0;
        end else begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_quo   <= n_quo;
            r_rem   <= n_rem;
            r_level <= n_level;
        end
    end

    `RTF_ASSERT_IMP(a_hold_full, i_clk, i_rst_n, r_phase == PH_HOLD, r_level == LEVEL_W'(FULL_LEVEL))
    `RTF_ASSERT_IMP(a_off_dark, i_clk, i_rst_n, r_phase == PH_OFF, r_level == '0 && r_quo == '0)
    `RTF_ASSERT_NXT(a_idle_hold, i_clk, i_rst_n, !i_adv, $stable(r_phase) && $stable(r_ticks))

endmodule

[rtl/rtf_scaler.sv]
// ----------------------------------------------------------------------------
// rtf_scaler
// Scale each color by level/255 and hold the result word.
// ----------------------------------------------------------------------------
module rtf_scaler (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  rtf_pkg::t_seq_state           i_state,
    input  rtf_pkg::t_cfg                 i_cfg,
    output logic [rtf_pkg::COLOR_W-1:0]   o_red_duty,
    output logic [rtf_pkg::COLOR_W-1:0]   o_green_duty,
    output logic [rtf_pkg::COLOR_W-1:0]   o_blue_duty,
    output logic [rtf_pkg::LEVEL_W-1:0]   o_brightness,
    output logic [1:0]                    o_fade_phase
);
    import rtf_pkg::*;

    // floor(c * l / 255) exact for any 8-bit pair
    function automatic logic [COLOR_W-1:0] scale_color(
        input logic [COLOR_W-1:0] color,
        input logic [LEVEL_W-1:0] level
    );
        logic [COLOR_W+LEVEL_W-1:0] prod;
        logic [COLOR_W+LEVEL_W:0]   acc;
        prod = color * level;
        acc  = {1'b0, prod} + (COLOR_W+LEVEL_W+1)'(prod[COLOR_W+LEVEL_W-1:LEVEL_W])
             + (COLOR_W+LEVEL_W+1)'(1);
        return acc[COLOR_W+LEVEL_W-1:LEVEL_W];
    endfunction

    logic [COLOR_W-1:0] r_red_duty;
    logic [COLOR_W-1:0] r_green_duty;
    logic [COLOR_W-1:0] r_blue_duty;
    logic [LEVEL_W-1:0] r_brightness;
    t_phase             r_fade_phase;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_red_duty   <= scale_color(i_cfg.red, i_state.level);
            r_green_duty <= scale_color(i_cfg.green, i_state.level);
            r_blue_duty  <= scale_color(i_cfg.blue, i_state.level);
            r_brightness <= i_state.level;
            r_fade_phase <= i_state.phase;
        end
    end

    assign o_red_duty   = r_red_duty;
    assign o_green_duty = r_green_duty;
    assign o_blue_duty  = r_blue_duty;
    assign o_brightness = r_brightness;
    assign o_fade_phase = r_fade_phase;

endmodule
